[rtl/flmi_pkg.sv]
// flmi_pkg: field widths, request codes and register indexes of the
// facility location mutual information gain engine.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package flmi_pkg;

  // field widths of the item and result channels
  localparam int QIDX_W      = 10;
  localparam int QCNT_W      = 11;
  localparam int SIM_W       = 16;
  localparam int LAMBDA_W    = 16;
  localparam int LAMBDA_FRAC = 12;
  localparam int GAIN_W      = 27;
  localparam int SETV_W      = 40;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [QCNT_W-1:0]   QUERIES_RST = 11'd1024;
  localparam logic [LAMBDA_W-1:0] LAMBDA_RST  = 16'd4096;

  // saturation limits
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [SETV_W-1:0] SETV_MAX = '1;

  // request codes of an item
  typedef enum logic [1:0] {
    REQ_PROBE  = 2'd0,
    REQ_COMMIT = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_type_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERIES = 1'b0,
    CFG_LAMBDA  = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/flmi_if.sv]
// flmi_if: valid/ready channel interfaces for similarity items and gain results.
// Depends on flmi_pkg for the field widths.
`default_nettype none

interface flmi_in_if;
  import flmi_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [QIDX_W-1:0]   query_index;
  logic [SIM_W-1:0]    similarity;
  logic                already_selected;

  modport source (
    output valid, req_type, query_index, similarity, already_selected,
    input  ready
  );
  modport sink (
    input  valid, req_type, query_index, similarity, already_selected,
    output ready
  );
endinterface

interface flmi_out_if;
  import flmi_pkg::*;

  logic                valid;
  logic                ready;
  logic [GAIN_W-1:0]   gain;
  logic [SETV_W-1:0]   set_value;

  modport source (
    output valid, gain, set_value,
    input  ready
  );
  modport sink (
    input  valid, gain, set_value,
    output ready
  );
endinterface

`default_nettype wire

[rtl/facility_location_mi_gain_core.sv]
// facility_location_mi_gain_core: streaming marginal gain engine with per-query
// best-similarity memory, running set totals and a registered result channel.
// Depends on flmi_pkg and the channel interfaces in flmi_if.sv.
`default_nettype none

// Takes one similarity item per clock while in_ch.ready is high. Items that
// neither end a row nor clear retire in the first stage; a row's last item
// travels four more registers (row totals, lambda product, set totals, set
// value), the last of which drives out_ch. Stages hold under back-pressure
// and in_ch.ready drops when the item in the first stage cannot advance or
// is a clear. The best-similarity memory has one write and one registered
// read port; a commit followed at once by an item on the same query is
// forwarded past the memory. After reset and after every clear item the
// memory is zeroed one entry per cycle, over all MAX_QUERIES entries, and no
// item is taken meanwhile; configuration writes are taken at any time.
module facility_location_mi_gain_core #(
  parameter int MAX_QUERIES = 1024,
  parameter int SIM_BITS    = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [flmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [flmi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  flmi_in_if.sink                               in_ch,
  flmi_out_if.source                            out_ch
);
  import flmi_pkg::*;

  localparam int AW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
  localparam int SW = (SIM_BITS < SIM_W) ? SIM_BITS : SIM_W;
  localparam int PW = LAMBDA_W + SW;
  localparam int WW = PW - LAMBDA_FRAC;
  localparam int XW = ((QIDX_W > AW) ? QIDX_W : AW) + 1;
  localparam logic [XW-1:0] DEPTH_X   = XW'(MAX_QUERIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_QUERIES - 1);

  // configuration registers
  logic [QCNT_W-1:0]   qcnt_r;
  logic [LAMBDA_W-1:0] lambda_r;
  logic [QCNT_W-1:0]   qlast;

  // input decode
  logic              accept;
  logic [XW-1:0]     in_q_x;
  logic              in_range;
  logic [AW-1:0]     in_addr;
  logic [SW-1:0]     in_sim;

  // best-similarity memory and clearing pass
  logic [SW-1:0]     best_mem [MAX_QUERIES];
  logic [SW-1:0]     rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [SW-1:0]     mem_wdata;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_cnt_r;

  // stage 1: per-element update
  logic              s1_v_r;
  logic [1:0]        s1_type_r;
  logic [QIDX_W-1:0] s1_q_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_inr_r;
  logic [SW-1:0]     s1_sim_r;
  logic              s1_sel_r;
  logic              fwd_hit_r;
  logic [SW-1:0]     fwd_data_r;
  logic              s1_pc;
  logic              s1_clr;
  logic [SW-1:0]     s1_best;
  logic [SW-1:0]     s1_diff;
  logic              s1_upd;
  logic              s1_gt;
  logic              s1_last;
  logic              s1_wr;
  logic              s1_pass;
  logic              s1_mv;
  logic [GAIN_W:0]   acc_sum;
  logic [GAIN_W-1:0] acc_sat;
  logic [GAIN_W-1:0] acc_nxt;
  logic [SW-1:0]     rmax_nxt;
  logic [GAIN_W-1:0] acc_r;
  logic [SW-1:0]     rmax_r;

  // stage 2: row totals
  logic              s2_v_r;
  logic              s2_clr_r;
  logic              s2_cmt_r;
  logic              s2_sel_r;
  logic [GAIN_W-1:0] s2_acc_r;
  logic [SW-1:0]     s2_rmax_r;
  logic              s2_ok;
  logic              s2_mv;
  logic [PW-1:0]     s2_prod;

  // stage 3: weighted maximum, set totals
  logic              s3_v_r;
  logic              s3_clr_r;
  logic              s3_cmt_r;
  logic              s3_sel_r;
  logic [GAIN_W-1:0] s3_acc_r;
  logic [WW-1:0]     s3_wt_r;
  logic              s3_ok;
  logic              s3_mv;
  logic [GAIN_W:0]   gain_sum;
  logic [GAIN_W-1:0] s3_gain;
  logic [GAIN_W:0]   cov_sum;
  logic [SETV_W:0]   wmt_sum;
  logic [GAIN_W-1:0] cov_r;
  logic [SETV_W-1:0] wmt_r;

  // stage 4 and output register
  logic              s4_v_r;
  logic [GAIN_W-1:0] s4_gain_r;
  logic              s4_ok;
  logic              s4_mv;
  logic [SETV_W:0]   setv_sum;
  logic              out_ok;
  logic              out_v_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic [SETV_W-1:0] out_setv_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r   <= QUERIES_RST;
      lambda_r <= LAMBDA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUERIES: qcnt_r   <= cfg_wdata[QCNT_W-1:0];
        CFG_LAMBDA:  lambda_r <= cfg_wdata[LAMBDA_W-1:0];
        default: ;
      endcase
    end
  end

  assign qlast = qcnt_r - QCNT_W'(1);

  // input decode
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_q_x   = XW'(in_ch.query_index);
  assign in_range = in_q_x < DEPTH_X;
  assign in_addr  = in_q_x[AW-1:0];
  assign in_sim   = in_ch.similarity[SW-1:0];

  // memory write port: clearing pass or commit of stage 1
  assign mem_we    = clr_busy_r || (s1_mv && s1_wr);
  assign mem_waddr = clr_busy_r ? clr_cnt_r : s1_addr_r;
  assign mem_wdata = clr_busy_r ? '0 : s1_sim_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      best_mem[mem_waddr] <= mem_wdata;
    end
  end

  // memory read port, one read per accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= best_mem[in_addr];
    end
  end

  // clearing pass after reset and after a clear item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
        clr_cnt_r  <= '0;
      end else begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end else if (s1_mv && s1_clr) begin
      clr_busy_r <= 1'b1;
    end
  end

  // stage 1 datapath
  assign s1_pc   = (s1_type_r == REQ_PROBE) || (s1_type_r == REQ_COMMIT);
  assign s1_clr  = s1_type_r == REQ_CLEAR;
  assign s1_best = !s1_inr_r ? '0 : (fwd_hit_r ? fwd_data_r : rd_data_r);
  assign s1_upd  = s1_pc && !s1_sel_r;
  assign s1_gt   = s1_sim_r > s1_best;
  assign s1_diff = s1_sim_r - s1_best;
  assign acc_sum = {1'b0, acc_r} + (GAIN_W+1)'(s1_diff);
  assign acc_sat = acc_sum[GAIN_W] ? GAIN_MAX : acc_sum[GAIN_W-1:0];
  assign acc_nxt = (s1_upd && s1_gt) ? acc_sat : acc_r;
  assign rmax_nxt = (s1_upd && (s1_sim_r > rmax_r)) ? s1_sim_r : rmax_r;
  assign s1_last = s1_pc && (QCNT_W'(s1_q_r) == qlast);
  assign s1_wr   = s1_upd && (s1_type_r == REQ_COMMIT) && s1_inr_r && s1_gt;
  assign s1_pass = s1_last || s1_clr;
  assign s1_mv   = s1_v_r && (!s1_pass || s2_ok);

  // a clear item holds off the next item until the clearing pass has ended
  assign in_ch.ready = !clr_busy_r && (!s1_v_r || (s1_mv && !s1_clr));

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (accept) begin
      s1_v_r    <= 1'b1;
      fwd_hit_r <= s1_v_r && s1_mv && s1_wr && (s1_addr_r == in_addr);
    end else if (s1_mv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type_r  <= in_ch.req_type;
      s1_q_r     <= in_ch.query_index;
      s1_addr_r  <= in_addr;
      s1_inr_r   <= in_range;
      s1_sim_r   <= in_sim;
      s1_sel_r   <= in_ch.already_selected;
      fwd_data_r <= s1_sim_r;
    end
  end

  // row accumulator and row maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      rmax_r <= '0;
    end else if (s1_mv) begin
      acc_r  <= s1_pass ? '0 : acc_nxt;
      rmax_r <= s1_pass ? '0 : rmax_nxt;
    end
  end

  // stage 2: row-end and clear items
  assign s2_mv   = s2_v_r && s3_ok;
  assign s2_ok   = !s2_v_r || s2_mv;
  assign s2_prod = PW'(lambda_r) * PW'(s2_rmax_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_mv && s1_pass) begin
      s2_v_r <= 1'b1;
    end else if (s2_mv) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv && s1_pass) begin
      s2_clr_r  <= s1_clr;
      s2_cmt_r  <= s1_type_r == REQ_COMMIT;
      s2_sel_r  <= s1_sel_r;
      s2_acc_r  <= acc_nxt;
      s2_rmax_r <= rmax_nxt;
    end
  end

  // stage 3: weighted maximum registered, totals updated on the way out
  assign s3_mv    = s3_v_r && s4_ok;
  assign s3_ok    = !s3_v_r || s3_mv;
  assign gain_sum = {1'b0, s3_acc_r} + (GAIN_W+1)'(s3_wt_r);
  assign s3_gain  = s3_sel_r ? '0 : (gain_sum[GAIN_W] ? GAIN_MAX : gain_sum[GAIN_W-1:0]);
  assign cov_sum  = {1'b0, cov_r} + (GAIN_W+1)'(s3_acc_r);
  assign wmt_sum  = {1'b0, wmt_r} + (SETV_W+1)'(s3_wt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s2_mv) begin
      s3_v_r <= 1'b1;
    end else if (s3_mv) begin
      s3_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_mv) begin
      s3_clr_r <= s2_clr_r;
      s3_cmt_r <= s2_cmt_r;
      s3_sel_r <= s2_sel_r;
      s3_acc_r <= s2_acc_r;
      s3_wt_r  <= s2_prod[PW-1:LAMBDA_FRAC];
    end
  end

  // set totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_r <= '0;
      wmt_r <= '0;
    end else if (s3_mv) begin
      if (s3_clr_r) begin
        cov_r <= '0;
        wmt_r <= '0;
      end else if (s3_cmt_r && !s3_sel_r) begin
        cov_r <= cov_sum[GAIN_W] ? GAIN_MAX : cov_sum[GAIN_W-1:0];
        wmt_r <= wmt_sum[SETV_W] ? SETV_MAX : wmt_sum[SETV_W-1:0];
      end
    end
  end

  // stage 4: gain waits while the totals settle
  assign out_ok   = !out_v_r || out_ch.ready;
  assign s4_mv    = s4_v_r && out_ok;
  assign s4_ok    = !s4_v_r || s4_mv;
  assign setv_sum = (SETV_W+1)'(cov_r) + {1'b0, wmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s3_mv && !s3_clr_r) begin
      s4_v_r <= 1'b1;
    end else if (s4_mv) begin
      s4_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_mv && !s3_clr_r) begin
      s4_gain_r <= s3_gain;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s4_mv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_mv) begin
      out_gain_r <= s4_gain_r;
      out_setv_r <= setv_sum[SETV_W] ? SETV_MAX : setv_sum[SETV_W-1:0];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.gain      = out_gain_r;
  assign out_ch.set_value = out_setv_r;

`ifndef SYNTH
  // no item taken while the memory is being zeroed
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(in_ch.valid && in_ch.ready))
    else $error("item accepted during clearing pass");

  // clearing pass and stage 1 never share the write port
  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_busy_r && s1_v_r))
    else $error("stage 1 busy during clearing pass");

  // row end and clear restart the row accumulators
  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_mv && s1_pass |=> acc_r == '0 && rmax_r == '0)
    else $error("row accumulators not restarted");

  // a selected candidate reports zero gain
  a_selected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s3_mv && !s3_clr_r && s3_sel_r |=> s4_gain_r == '0)
    else $error("selected candidate with nonzero gain");

  // a clear empties the set totals
  a_clear_totals: assert property (@(posedge clk) disable iff (!rst_n)
    s3_mv && s3_clr_r |=> cov_r == '0 && wmt_r == '0)
    else $error("set totals not cleared");
`endif

endmodule

`default_nettype wire

[tb/flmi_gain_checker.sv]
`timescale 1ns / 1ps
// flmi_gain_checker: watches the item, result and register ports of the gain engine,
// predicts every result and compares it with what the engine delivers.
// Depends on flmi_pkg and the channel interfaces in flmi_if.sv.

module flmi_gain_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [flmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [flmi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  flmi_in_if                                    in_ch,
  flmi_out_if                                   out_ch,
  output int unsigned                           fail_total,
  output int unsigned                           results_waiting,
  output int unsigned                           results_seen
);
  import flmi_pkg::*;

  localparam int NUM_QUERIES = 1024;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [SETV_W-1:0] set_value;
  } gain_result_t;

  // predicted results, oldest first
  gain_result_t results_due[$];

  // engine state as predicted
  logic [SIM_W-1:0]    best_sim [NUM_QUERIES];
  logic [GAIN_W-1:0]   row_gain;
  logic [SIM_W-1:0]    row_max;
  logic [GAIN_W-1:0]   covered_total;
  logic [SETV_W-1:0]   weighted_total;
  logic [QCNT_W-1:0]   queries;
  logic [LAMBDA_W-1:0] lambda;

  function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] cap);
    logic [63:0] sum;
    sum = a + b;
    return (sum > cap) ? cap : sum;
  endfunction

  task automatic clear_store();
    foreach (best_sim[i]) best_sim[i] = '0;
    row_gain       = '0;
    row_max        = '0;
    covered_total  = '0;
    weighted_total = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_total < PRINT_LIMIT)
      $display("error at %0t ns: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
    fail_total++;
  endtask

  // one similarity item through the gain datapath
  task automatic take_element(input logic [1:0] req, input logic [QIDX_W-1:0] qi,
                              input logic [SIM_W-1:0] sim, input logic sel);
    logic [SIM_W-1:0]  best;
    logic [QCNT_W-1:0] last_q;
    logic [63:0]       weighted;
    gain_result_t      res;
    if (req == REQ_CLEAR) begin
      clear_store();
      return;
    end
    if (req != REQ_PROBE && req != REQ_COMMIT) return;
    best = best_sim[qi];
    // flagged items leave the row and the bests alone
    if (!sel) begin
      if (sim > best) row_gain = GAIN_W'(add_capped(row_gain, sim - best, GAIN_MAX));
      if (sim > row_max) row_max = sim;
      if (req == REQ_COMMIT && sim > best) best_sim[qi] = sim;
    end
    last_q = queries - 1'b1;
    if ({1'b0, qi} != last_q) return;
    // row end: weighted maximum, totals on commit, then the result
    weighted = (64'(lambda) * 64'(row_max)) >> LAMBDA_FRAC;
    if (sel) begin
      res.gain = '0;
    end else begin
      res.gain = GAIN_W'(add_capped(row_gain, weighted, GAIN_MAX));
      if (req == REQ_COMMIT) begin
        covered_total  = GAIN_W'(add_capped(covered_total, row_gain, GAIN_MAX));
        weighted_total = SETV_W'(add_capped(weighted_total, weighted, SETV_MAX));
      end
    end
    row_gain      = '0;
    row_max       = '0;
    res.set_value = SETV_W'(add_capped(covered_total, weighted_total, SETV_MAX));
    results_due.insert(results_due.size(), res);
  endtask

  // predict on accepted items, compare on accepted results
  always @(posedge clk) begin
    gain_result_t want;
    if (!rst_n) begin
      clear_store();
      queries = QUERIES_RST;
      lambda  = LAMBDA_RST;
      results_due.delete();
      fail_total   = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_QUERIES) queries = cfg_wdata[QCNT_W-1:0];
        else lambda = cfg_wdata[LAMBDA_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result gain", 64'(out_ch.gain), 64'd0);
        end else begin
          want = results_due.pop_front();
          if (out_ch.gain !== want.gain)
            report_mismatch("gain", 64'(out_ch.gain), 64'(want.gain));
          if (out_ch.set_value !== want.set_value)
            report_mismatch("set_value", 64'(out_ch.set_value), 64'(want.set_value));
        end
      end
      if (in_ch.valid && in_ch.ready)
        take_element(in_ch.req_type, in_ch.query_index, in_ch.similarity,
                     in_ch.already_selected);
    end
    results_waiting = results_due.size();
  end

endmodule

[tb/facility_location_mi_gain_core_test.sv]
`timescale 1ns / 1ps
// facility_location_mi_gain_core_test: clock, reset, item and register stimulus with
// random stalls on both channels for the gain engine; verdict from flmi_gain_checker.
// Depends on flmi_pkg, flmi_if.sv, the core and tb/flmi_gain_checker.sv.

module facility_location_mi_gain_core_test;
  import flmi_pkg::*;

  localparam logic [1:0] REQ_SPARE     = 2'd3;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  flmi_in_if  in_ch ();
  flmi_out_if out_ch ();

  int unsigned fail_total;
  int unsigned results_waiting;
  int unsigned results_seen;

  int          send_idle_pct;
  int          recv_idle_pct;
  logic        start_hold;
  logic        hold_results;
  int unsigned items_sent;
  int unsigned clears_sent;
  int unsigned row_len;

  facility_location_mi_gain_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  flmi_gain_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_total      (fail_total),
    .results_waiting (results_waiting),
    .results_seen    (results_seen)
  );

  always #1 clk = ~clk;

  // result side: random stalls, plus one long hold-off
  always @(negedge clk) begin
    out_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    hold_results = 1'b0;
    wait (start_hold);
    @(negedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_results <= 1'b0;
  end

  initial begin
    #2000000;
    $display("facility_location_mi_gain_core: mismatch");
    $finish;
  end

  function automatic logic [SIM_W-1:0] random_sim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SIM_W'($urandom_range(255));
      default: return SIM_W'($urandom_range(65535));
    endcase
  endfunction

  // offer one item after a random gap, return once it is taken
  task automatic send_item(input logic [1:0] req, input logic [QIDX_W-1:0] qi,
                           input logic [SIM_W-1:0] sim, input logic sel);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.req_type         <= req;
    in_ch.query_index      <= qi;
    in_ch.similarity       <= sim;
    in_ch.already_selected <= sel;
    do @(posedge clk); while (!in_ch.ready);
    if (req != REQ_SPARE) items_sent++;
    if (req == REQ_CLEAR) clears_sent++;
  endtask

  // register writes only once the engine has drained
  task automatic configure(input logic [QCNT_W-1:0] queries,
                           input logic [LAMBDA_W-1:0] lambda);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUERIES;
    cfg_wdata <= CFG_DATA_W'(queries);
    @(negedge clk);
    cfg_index <= CFG_LAMBDA;
    cfg_wdata <= lambda;
    @(negedge clk);
    cfg_we  <= 1'b0;
    row_len = 32'(queries);
  endtask

  // one candidate row in query order; long rows start close to their end
  task automatic random_row(input int unsigned len);
    logic [1:0]  row_req;
    logic        row_sel;
    logic [1:0]  req;
    logic        sel;
    int unsigned first_q;
    row_req = ($urandom_range(99) < 45) ? REQ_COMMIT : REQ_PROBE;
    row_sel = ($urandom_range(99) < 12);
    first_q = (len > 24) ? len - 1 - $urandom_range(5) : 0;
    for (int unsigned q = first_q; q < len; q++) begin
      req = row_req;
      sel = row_sel;
      if ($urandom_range(99) < 8) req = (row_req == REQ_COMMIT) ? REQ_PROBE : REQ_COMMIT;
      if ($urandom_range(99) < 5) sel = !sel;
      send_item(req, QIDX_W'(q), random_sim(), sel);
    end
  endtask

  // mostly well-formed rows, some stray items and a rare clear
  task automatic random_phase(input int unsigned budget);
    int unsigned goal;
    int unsigned clears_here;
    int unsigned pick;
    logic [1:0]  req;
    goal        = items_sent + budget;
    clears_here = 0;
    while (items_sent < goal) begin
      pick = $urandom_range(999);
      if (pick < 8 && clears_here < 2) begin
        send_item(REQ_CLEAR, QIDX_W'($urandom_range(1023)), random_sim(), 1'($urandom));
        clears_here++;
      end else if (pick < 130) begin
        case ($urandom_range(2))
          0:       req = REQ_PROBE;
          1:       req = REQ_COMMIT;
          default: req = REQ_SPARE;
        endcase
        send_item(req, QIDX_W'($urandom_range(1023)), random_sim(), 1'($urandom));
      end else begin
        random_row(row_len);
      end
    end
  endtask

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_QUERIES;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.req_type         = REQ_PROBE;
    in_ch.query_index      = '0;
    in_ch.similarity       = '0;
    in_ch.already_selected = 1'b0;
    start_hold             = 1'b0;
    send_idle_pct          = 38;
    recv_idle_pct          = 85;
    items_sent             = 0;
    clears_sent            = 0;
    row_len                = 32'(QUERIES_RST);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // short rows of hand-picked items
    configure(11'd2, LAMBDA_RST);
    send_item(REQ_PROBE, 10'd0, 16'hFFFF, 1'b0);
    send_item(REQ_PROBE, 10'd1, 16'h0000, 1'b0);
    // commit raises the stored bests
    send_item(REQ_COMMIT, 10'd0, 16'h8000, 1'b0);
    send_item(REQ_COMMIT, 10'd1, 16'h1234, 1'b0);
    // below the bests: gain from the row maximum only
    send_item(REQ_PROBE, 10'd0, 16'h0100, 1'b0);
    send_item(REQ_PROBE, 10'd1, 16'h0001, 1'b0);
    // candidate already in the set
    send_item(REQ_COMMIT, 10'd0, 16'hFFFF, 1'b1);
    send_item(REQ_COMMIT, 10'd1, 16'hFFFF, 1'b1);
    // mixed row, probe at the end keeps the totals
    send_item(REQ_COMMIT, 10'd0, 16'hFFFF, 1'b0);
    send_item(REQ_PROBE, 10'd1, 16'h4000, 1'b0);
    // commit row whose last item is flagged
    send_item(REQ_COMMIT, 10'd0, 16'h2000, 1'b0);
    send_item(REQ_COMMIT, 10'd1, 16'hC000, 1'b1);
    // unused request code
    send_item(REQ_SPARE, 10'd1, 16'hFFFF, 1'b0);
    // clear, then a row on an empty store
    send_item(REQ_CLEAR, 10'd0, 16'h0000, 1'b0);
    send_item(REQ_COMMIT, 10'd0, 16'h00FF, 1'b0);
    send_item(REQ_COMMIT, 10'd1, 16'hFF00, 1'b0);
    // full query count: row ends at the top index
    configure(11'd1024, 16'hFFFF);
    send_item(REQ_PROBE, 10'd1022, 16'h7FFF, 1'b0);
    send_item(REQ_COMMIT, 10'd1023, 16'hFFFF, 1'b0);
    // count past the index range: rows never end
    configure(11'd2047, 16'h0000);
    send_item(REQ_COMMIT, 10'd1023, 16'h1111, 1'b0);
    send_item(REQ_PROBE, 10'd0, 16'hFFFF, 1'b1);
    send_item(REQ_CLEAR, 10'd0, 16'h0000, 1'b0);

    // zero count: one long unterminated stretch builds a large row sum
    configure(11'd0, LAMBDA_RST);
    for (int i = 0; i < 200; i++) send_item(REQ_PROBE, QIDX_W'(i), 16'hFFFF, 1'b0);
    configure(11'd1, LAMBDA_RST);
    send_item(REQ_COMMIT, 10'd0, 16'hFFFF, 1'b0);
    send_item(REQ_COMMIT, 10'd0, 16'h8000, 1'b0);
    send_item(REQ_CLEAR, 10'd0, 16'h0000, 1'b0);

    // random rows, sender idles less than the receiver
    configure(11'd5, LAMBDA_RST);
    random_phase(70);
    configure(11'd1, 16'h0000);
    random_phase(70);

    // receiver idles less than the sender
    send_idle_pct <= 85;
    recv_idle_pct <= 38;
    configure(11'd3, 16'hFFFF);
    random_phase(70);
    configure(11'd1024, LAMBDA_W'($urandom_range(65535)));
    random_phase(70);

    // no idling; the long hold-off backs up the engine
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    configure(11'd9, LAMBDA_W'($urandom_range(65535)));
    start_hold = 1'b1;
    random_phase(70);
    configure(11'd2, 16'h0001);
    random_phase(70);

    // drain
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("run: %0d items including %0d clears, %0d results checked", items_sent,
             clears_sent, results_seen);
    $display("run: row lengths 1 to 1024, unterminated rows, lambda 0 to 65535, long stall");
    if (fail_total == 0 && results_waiting == 0) begin
      $display("facility_location_mi_gain_core: match");
    end else begin
      $display("facility_location_mi_gain_core: mismatch");
    end
    $finish;
  end

endmodule
